// ----- rtl/etc_pkg.sv -----
// ============================================================================
// etc_pkg - shared types, constants and arithmetic helpers
// Wrapping 32-bit helpers, register indexes and stage counts used by the
// environmental sensor compensation pipeline.
// ============================================================================
package etc_pkg;

	localparam int unsigned TEMP_LAT  = 5;
	localparam int unsigned DIV_STAGES = 32;
	localparam int unsigned PRESS_LAT = 8 + DIV_STAGES + 5;
	localparam int unsigned HUM_LAT   = 11;
	localparam int unsigned TOTAL_LAT = TEMP_LAT + PRESS_LAT;

	localparam logic [31:0] HUM_MAX   = 32'd100000;
	localparam logic [63:0] RECIP_100 = 64'd1374389535;

	typedef enum logic [2:0] {
		REG_TEMP    = 3'd0,
		REG_PRESS_A = 3'd1,
		REG_PRESS_B = 3'd2,
		REG_PRESS_C = 3'd3,
		REG_HUM     = 3'd4
	} reg_idx_t;

	// Truncating divide by 100 split in two halves: sign and scaled magnitude.
	typedef struct packed {
		logic        neg;
		logic [26:0] mag;
	} d100_t;

	function automatic logic [31:0] asr(logic [31:0] v, int unsigned s);
		return 32'($signed(v) >>> s);
	endfunction

	function automatic logic [31:0] mul32(logic [31:0] a, logic [31:0] b);
		logic [63:0] p;
		p = {32'd0, a} * {32'd0, b};
		return p[31:0];
	endfunction

	function automatic logic [31:0] sx8(logic [7:0] v);
		return {{24{v[7]}}, v};
	endfunction

	function automatic logic [31:0] sx16(logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic d100_t d100_a(logic [31:0] v);
		logic [31:0] u;
		logic [63:0] p;
		d100_t       r;
		u = v[31] ? (~v + 32'd1) : v;
		p = {32'd0, u} * RECIP_100;
		r.neg = v[31];
		r.mag = p[63:37];
		return r;
	endfunction

	function automatic logic [31:0] d100_b(d100_t x);
		logic [31:0] q;
		q = {5'd0, x.mag};
		return x.neg ? (~q + 32'd1) : q;
	endfunction

endpackage

// ----- rtl/etc_temp.sv -----
// ============================================================================
// etc_temp - temperature compensation stages
// Five register stages from raw temperature to fine temperature and
// centi-degrees; raw pressure and humidity words ride along.
// ============================================================================
module etc_temp import etc_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [39:0] temp_calib,
	input  logic [19:0] raw_temp,
	input  logic [19:0] raw_press,
	input  logic [15:0] raw_hum,
	output logic [31:0] temp,
	output logic [31:0] fine,
	output logic [19:0] rp_out,
	output logic [15:0] rh_out
);

	logic [31:0] t1, t2, t3;
	logic [31:0] a_s1, m1_s2, m2_s2, b_s3, m3_s3, fine_s4, fine_s5, temp_s5;
	logic [19:0] rp_s1, rp_s2, rp_s3, rp_s4, rp_s5;
	logic [15:0] rh_s1, rh_s2, rh_s3, rh_s4, rh_s5;

	assign t1 = {16'd0, temp_calib[15:0]};
	assign t2 = sx16(temp_calib[31:16]);
	assign t3 = sx8(temp_calib[39:32]);

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1    <= {15'd0, raw_temp[19:3]} - {t1[30:0], 1'b0};
			m1_s2   <= mul32(a_s1, t2);
			m2_s2   <= mul32(asr(a_s1, 1), asr(a_s1, 1));
			b_s3    <= asr(m1_s2, 11);
			m3_s3   <= mul32(asr(m2_s2, 12), {t3[27:0], 4'd0});
			fine_s4 <= b_s3 + asr(m3_s3, 14);
			fine_s5 <= fine_s4;
			temp_s5 <= asr({fine_s4[29:0], 2'd0} + fine_s4 + 32'd128, 8);
			rp_s1 <= raw_press; rp_s2 <= rp_s1; rp_s3 <= rp_s2; rp_s4 <= rp_s3;
			rp_s5 <= rp_s4;
			rh_s1 <= raw_hum; rh_s2 <= rh_s1; rh_s3 <= rh_s2; rh_s4 <= rh_s3;
			rh_s5 <= rh_s4;
		end
	end

	assign temp   = temp_s5;
	assign fine   = fine_s5;
	assign rp_out = rp_s5;
	assign rh_out = rh_s5;

endmodule

// ----- rtl/etc_div.sv -----
// ============================================================================
// etc_div - pipelined unsigned divider
// Restoring 32-bit by 32-bit division, one quotient bit per stage; two
// side bits travel with each request.
// ============================================================================
module etc_div import etc_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	input  logic [1:0]  side_in,
	output logic [31:0] quotient,
	output logic [1:0]  side_out
);

	logic [31:0] rem_s  [DIV_STAGES];
	logic [31:0] quo_s  [DIV_STAGES];
	logic [31:0] dvd_s  [DIV_STAGES];
	logic [31:0] dvs_s  [DIV_STAGES];
	logic [1:0]  side_s [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [31:0] rem_i, quo_i, dvd_i, dvs_i;
		logic [1:0]  side_i;
		logic [32:0] trial, diff;

		if (k == 0) begin : g_first
			assign rem_i  = '0;
			assign quo_i  = '0;
			assign dvd_i  = dividend;
			assign dvs_i  = divisor;
			assign side_i = side_in;
		end else begin : g_next
			assign rem_i  = rem_s[k-1];
			assign quo_i  = quo_s[k-1];
			assign dvd_i  = dvd_s[k-1];
			assign dvs_i  = dvs_s[k-1];
			assign side_i = side_s[k-1];
		end

		assign trial = {rem_i, dvd_i[31]};
		assign diff  = trial - {1'b0, dvs_i};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= diff[32] ? trial[31:0] : diff[31:0];
				quo_s[k]  <= {quo_i[30:0], ~diff[32]};
				dvd_s[k]  <= {dvd_i[30:0], 1'b0};
				dvs_s[k]  <= dvs_i;
				side_s[k] <= side_i;
			end
		end
	end

	assign quotient = quo_s[DIV_STAGES-1];
	assign side_out = side_s[DIV_STAGES-1];

endmodule

// ----- rtl/etc_press.sv -----
// ============================================================================
// etc_press - pressure compensation stages
// Builds numerator and divisor from fine temperature, divides through the
// pipelined divider, then applies the second-order correction.
// ============================================================================
module etc_press import etc_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [55:0] press_calib_a,
	input  logic [47:0] press_calib_b,
	input  logic [23:0] press_calib_c,
	input  logic [31:0] fine,
	input  logic [19:0] raw_press,
	output logic [31:0] press
);

	logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, p10;
	logic [31:0] pa_s1, sq_s2, m5_s2, m4_s2, x1_s3, x2_s3, m5_s3, m4_s3;
	logic [31:0] b_s4, a_s4, a2_s5, b_s5, dv_s6, num_s6, n_s7, dv_s7;
	logic [31:0] dvd_s8, dvs_s8;
	logic [1:0]  side_s8, side_div;
	logic [19:0] rp_s1, rp_s2, rp_s3, rp_s4, rp_s5;
	logic [31:0] quo;
	logic [31:0] p_q1, p_q2, s_q2, r2m_q2, t_q2, tt_q2;
	logic [31:0] p_q3, s2_q3, r2m_q3, ttt_q3;
	logic [31:0] p_q4, s2_q4, r2m_q4, r3m_q4, press_q5;
	logic        z_q1, z_q2, z_q3, z_q4;
	logic [31:0] corr;

	assign p1  = {16'd0, press_calib_a[15:0]};
	assign p2  = sx16(press_calib_a[31:16]);
	assign p3  = sx8(press_calib_a[39:32]);
	assign p4  = sx16(press_calib_a[55:40]);
	assign p5  = sx16(press_calib_b[15:0]);
	assign p6  = sx8(press_calib_b[23:16]);
	assign p7  = sx8(press_calib_b[31:24]);
	assign p8  = sx16(press_calib_b[47:32]);
	assign p9  = sx16(press_calib_c[15:0]);
	assign p10 = {24'd0, press_calib_c[23:16]};

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s1  <= asr(fine, 1) - 32'd64000;
			sq_s2  <= mul32(asr(pa_s1, 2), asr(pa_s1, 2));
			m5_s2  <= mul32(pa_s1, p5);
			m4_s2  <= mul32(p2, pa_s1);
			x1_s3  <= mul32(asr(sq_s2, 11), p6);
			x2_s3  <= mul32(asr(sq_s2, 13), {p3[26:0], 5'd0});
			m5_s3  <= m5_s2;
			m4_s3  <= m4_s2;
			b_s4   <= asr(asr(x1_s3, 2) + {m5_s3[30:0], 1'b0}, 2) + {p4[15:0], 16'd0};
			a_s4   <= asr(asr(x2_s3, 3) + asr(m4_s3, 1), 18);
			a2_s5  <= mul32(32'd32768 + a_s4, p1);
			b_s5   <= b_s4;
			dv_s6  <= asr(a2_s5, 15);
			num_s6 <= (32'd1048576 - {12'd0, rp_s5}) - asr(b_s5, 12);
			n_s7   <= mul32(num_s6, 32'd3125);
			dv_s7  <= dv_s6;
			// Large numerator: divide first, double afterwards.
			dvd_s8  <= n_s7[31] ? n_s7 : {n_s7[30:0], 1'b0};
			dvs_s8  <= dv_s7;
			side_s8 <= {n_s7[31], (dv_s7 == 32'd0)};
			rp_s1 <= raw_press; rp_s2 <= rp_s1; rp_s3 <= rp_s2; rp_s4 <= rp_s3;
			rp_s5 <= rp_s4;
		end
	end

	etc_div u_div (
		.clk      (clk),
		.en       (en),
		.dividend (dvd_s8),
		.divisor  (dvs_s8),
		.side_in  (side_s8),
		.quotient (quo),
		.side_out (side_div)
	);

	assign corr = asr(asr(s2_q4, 12) + asr(r2m_q4, 13) + asr(r3m_q4, 17)
		+ {p7[24:0], 7'd0}, 4);

	always_ff @(posedge clk) begin
		if (en) begin
			z_q1   <= side_div[0];
			p_q1   <= side_div[0] ? 32'd0 : (side_div[1] ? {quo[30:0], 1'b0} : quo);
			s_q2   <= mul32(p_q1 >> 3, p_q1 >> 3);
			r2m_q2 <= mul32(p_q1 >> 2, p8);
			t_q2   <= p_q1 >> 8;
			tt_q2  <= mul32(p_q1 >> 8, p_q1 >> 8);
			p_q2   <= p_q1;
			z_q2   <= z_q1;
			s2_q3  <= mul32(p9, s_q2 >> 13);
			ttt_q3 <= mul32(tt_q2, t_q2);
			r2m_q3 <= r2m_q2;
			p_q3   <= p_q2;
			z_q3   <= z_q2;
			r3m_q4 <= mul32(ttt_q3, p10);
			s2_q4  <= s2_q3;
			r2m_q4 <= r2m_q3;
			p_q4   <= p_q3;
			z_q4   <= z_q3;
			press_q5 <= z_q4 ? 32'd0 : p_q4 + corr;
		end
	end

	assign press = press_q5;

endmodule

// ----- rtl/etc_hum.sv -----
// ============================================================================
// etc_hum - humidity compensation stages
// Eleven register stages from compensated temperature and raw humidity to
// clamped milli-percent.
// ============================================================================
module etc_hum import etc_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] hum_calib,
	input  logic [31:0] temp,
	input  logic [15:0] raw_hum,
	output logic [16:0] hum
);

	logic [31:0] h3, h4, h5, h7;
	logic [31:0] m3_s1, m4_s1, m5_s1, m7_s1, temp_s1, temp_s2;
	logic [15:0] rh_s1, rh_s2;
	d100_t       d3_s2, d4_s2, d5_s2, d7_s2, y_s4;
	logic [31:0] r1_s3, r4_s3, m_s3, d4_s3;
	logic [31:0] r1_s4, r4_s4, d4_s4;
	logic [31:0] r1_s5, r4_s5, r2_s5;
	logic [31:0] r1_s6, r4_s6, m_s6;
	logic [31:0] r3_s7, r4_s7;
	logic [31:0] r3_s8, r4_s8, r5m_s8;
	logic [31:0] r3_s9, r6m_s9, m_s10;
	logic [16:0] hum_s11;
	logic [31:0] d3, d5, d7, hv;

	assign h3 = sx8(hum_calib[31:24]);
	assign h4 = sx8(hum_calib[39:32]);
	assign h5 = sx8(hum_calib[47:40]);
	assign h7 = sx8(hum_calib[63:56]);
	assign d3 = d100_b(d3_s2);
	assign d5 = d100_b(d5_s2);
	assign d7 = d100_b(d7_s2);
	assign hv = asr(m_s10, 12);

	always_ff @(posedge clk) begin
		if (en) begin
			m3_s1   <= mul32(temp, h3);
			m4_s1   <= mul32(temp, h4);
			m5_s1   <= mul32(temp, h5);
			m7_s1   <= mul32(temp, h7);
			temp_s1 <= temp;
			rh_s1   <= raw_hum;
			d3_s2   <= d100_a(m3_s1);
			d4_s2   <= d100_a(m4_s1);
			d5_s2   <= d100_a(m5_s1);
			d7_s2   <= d100_a(m7_s1);
			temp_s2 <= temp_s1;
			rh_s2   <= rh_s1;
			r1_s3   <= {16'd0, rh_s2} - {16'd0, hum_calib[11:0], 4'd0} - asr(d3, 1);
			r4_s3   <= asr({17'd0, hum_calib[55:48], 7'd0} + d7, 4);
			m_s3    <= mul32(temp_s2, d5);
			d4_s3   <= d100_b(d4_s2);
			y_s4    <= d100_a(asr(m_s3, 6));
			r1_s4   <= r1_s3;
			r4_s4   <= r4_s3;
			d4_s4   <= d4_s3;
			r2_s5   <= d4_s4 + d100_b(y_s4) + 32'd16384;
			r1_s5   <= r1_s4;
			r4_s5   <= r4_s4;
			m_s6    <= mul32({20'd0, hum_calib[23:12]}, r2_s5);
			r1_s6   <= r1_s5;
			r4_s6   <= r4_s5;
			r3_s7   <= mul32(r1_s6, asr(m_s6, 10));
			r4_s7   <= r4_s6;
			r5m_s8  <= mul32(asr(r3_s7, 14), asr(r3_s7, 14));
			r3_s8   <= r3_s7;
			r4_s8   <= r4_s7;
			r6m_s9  <= mul32(r4_s8, asr(r5m_s8, 10));
			r3_s9   <= r3_s8;
			m_s10   <= mul32(asr(r3_s9 + asr(r6m_s9, 1), 10), 32'd1000);
			// Clamp to 0 .. 100000.
			if (hv[31])
				hum_s11 <= '0;
			else if (hv > HUM_MAX)
				hum_s11 <= HUM_MAX[16:0];
			else
				hum_s11 <= hv[16:0];
		end
	end

	assign hum = hum_s11;

endmodule

// ----- rtl/env_sensor_compensation.sv -----
// ============================================================================
// env_sensor_compensation - temperature / pressure / humidity compensation
// Integer compensation of one raw sensor measurement per request.
// ============================================================================
// One request carries raw 20-bit temperature, 20-bit pressure and 16-bit
// humidity words; one result comes back per request with temperature in
// centi-degrees C, pressure in Pa (0 when the pressure divisor is zero) and
// humidity in milli-percent clamped to 0..100000. The block is a fixed
// pipeline of 50 register stages: 5 for temperature, then 45 for pressure,
// dominated by a 32-stage restoring divider that produces one quotient bit
// per stage; humidity (11 stages) runs beside pressure and waits in a delay
// line. A new request may enter every cycle while in_stall is low, and
// one result leaves per cycle. The whole pipeline holds while a finished
// result is stalled at the output. Calibration words are written over the
// APB port at byte address 8*i (temp, press a/b/c, hum) and must only change
// while no request is in flight.
module env_sensor_compensation import etc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [5:0]         paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [19:0]        raw_temp,
	input  logic [19:0]        raw_press,
	input  logic [15:0]        raw_hum,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] temp_centi_c,
	output logic [31:0]        press_pa,
	output logic [16:0]        hum_milli_pct
);

	localparam int unsigned HUM_DLY = PRESS_LAT - HUM_LAT;

	logic [39:0] temp_calib_q;
	logic [55:0] press_a_q;
	logic [47:0] press_b_q;
	logic [23:0] press_c_q;
	logic [63:0] hum_q;
	logic        adv;
	logic        vld_q [TOTAL_LAT];
	logic [31:0] temp_dly_q [PRESS_LAT];
	logic [16:0] hum_dly_q [HUM_DLY];
	logic [31:0] temp_w, fine_w, press_w;
	logic [19:0] rp_w;
	logic [15:0] rh_w;
	logic [16:0] hum_w;
	reg_idx_t    idx;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[5:3]);

	// Calibration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_calib_q <= '0;
			press_a_q    <= '0;
			press_b_q    <= '0;
			press_c_q    <= '0;
			hum_q        <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_TEMP:    temp_calib_q <= pwdata[39:0];
				REG_PRESS_A: press_a_q    <= pwdata[55:0];
				REG_PRESS_B: press_b_q    <= pwdata[47:0];
				REG_PRESS_C: press_c_q    <= pwdata[23:0];
				REG_HUM:     hum_q        <= pwdata;
				default: ;
			endcase
		end
	end

	// Register readback
	always_comb begin
		unique case (idx)
			REG_TEMP:    prdata = {24'd0, temp_calib_q};
			REG_PRESS_A: prdata = {8'd0, press_a_q};
			REG_PRESS_B: prdata = {16'd0, press_b_q};
			REG_PRESS_C: prdata = {40'd0, press_c_q};
			REG_HUM:     prdata = hum_q;
			default:     prdata = '0;
		endcase
	end

	// Advance the whole pipeline unless the output result is held.
	assign adv      = !(vld_q[TOTAL_LAT-1] && out_stall);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TOTAL_LAT; i++)
				vld_q[i] <= 1'b0;
		end else if (adv) begin
			vld_q[0] <= in_valid;
			for (int i = 1; i < TOTAL_LAT; i++)
				vld_q[i] <= vld_q[i-1];
		end
	end

	etc_temp u_temp (
		.clk        (clk),
		.en         (adv),
		.temp_calib (temp_calib_q),
		.raw_temp   (raw_temp),
		.raw_press  (raw_press),
		.raw_hum    (raw_hum),
		.temp       (temp_w),
		.fine       (fine_w),
		.rp_out     (rp_w),
		.rh_out     (rh_w)
	);

	etc_press u_press (
		.clk           (clk),
		.en            (adv),
		.press_calib_a (press_a_q),
		.press_calib_b (press_b_q),
		.press_calib_c (press_c_q),
		.fine          (fine_w),
		.raw_press     (rp_w),
		.press         (press_w)
	);

	etc_hum u_hum (
		.clk       (clk),
		.en        (adv),
		.hum_calib (hum_q),
		.temp      (temp_w),
		.raw_hum   (rh_w),
		.hum       (hum_w)
	);

	// Align temperature and humidity with the pressure result.
	always_ff @(posedge clk) begin
		if (adv) begin
			temp_dly_q[0] <= temp_w;
			for (int i = 1; i < PRESS_LAT; i++)
				temp_dly_q[i] <= temp_dly_q[i-1];
			hum_dly_q[0] <= hum_w;
			for (int i = 1; i < HUM_DLY; i++)
				hum_dly_q[i] <= hum_dly_q[i-1];
		end
	end

	assign out_valid     = vld_q[TOTAL_LAT-1];
	assign temp_centi_c  = $signed(temp_dly_q[PRESS_LAT-1]);
	assign press_pa      = press_w;
	assign hum_milli_pct = hum_dly_q[HUM_DLY-1];

endmodule
